### design/rlff_pkg.sv
// Shared types and constants of the raster line and flood fill engine.
`default_nettype none

package rlff_pkg;

  // Field widths fixed by the item format
  localparam int CRD_W = 6;
  localparam int COL_W = 8;
  localparam int PIX_W = 24;
  localparam int CFG_W = 7;

  localparam logic [PIX_W-1:0] WHITE = 24'hFFFFFF;

  // Configuration register indexes
  localparam logic CFG_WIDTH_IDX  = 1'b0;
  localparam logic CFG_HEIGHT_IDX = 1'b1;

  // Request codes
  typedef enum logic [1:0] {
    REQ_SET  = 2'd0,
    REQ_LINE = 2'd1,
    REQ_FILL = 2'd2,
    REQ_READ = 2'd3
  } req_t;

  // Controller states
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_ADDR,
    ST_PIX_ACC,
    ST_PIX_CAP,
    ST_LN_PREP,
    ST_LN_INIT,
    ST_LN_MOD,
    ST_LN_ADDR,
    ST_LN_WR,
    ST_FL_ADDR,
    ST_FL_RD,
    ST_FL_CHK,
    ST_FL_CLRV,
    ST_FL_SEED,
    ST_FL_POP,
    ST_FL_PXY,
    ST_FL_PADDR,
    ST_FL_PRD,
    ST_FL_PCHK,
    ST_FL_NB,
    ST_FL_NRD,
    ST_FL_NCHK,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic cap_in;
    logic clr_fb;
    logic clr_vis;
    logic pix_addr;
    logic pix_wr;
    logic pix_cap;
    logic ln_prep;
    logic ln_init;
    logic mod_step;
    logic ln_addr;
    logic ln_wr;
    logic fl_chk;
    logic seed;
    logic pop;
    logic pxy;
    logic paddr;
    logic pwr;
    logic nb;
    logic nchk;
    logic dir_inc;
    logic res_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic ln_end;
    logic fl_reject;
    logic cnt_zero;
    logic pix_match;
    logic nvalid;
    logic dir_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### design/raster_line_and_flood_fill.sv
// Top level of the raster line and flood fill engine.
// Requests enter on the s_ channel: set pixel, draw line, flood fill or read
// pixel. Each request gives exactly one result item on the m_ channel with
// the read colour (zero unless a read) and a status bit (1 = ignored).
// Surface width and height are written on the cfg port while idle.
// One request is worked at a time; s_tready is high only when idle.
// Set and read pixel form the address, then write or read the framebuffer.
// Draw line first reduces the wrapped start point modulo the surface size
// in the remainder unit, then writes one drawn pixel per step. Flood fill
// checks the seed pixel, sweeps the visited map clear, then pops entries
// and checks up to four neighbors of each; a rejected seed ends it there.
// After reset the framebuffer is swept to white, one entry a cycle, over all
// MAX_WIDTH*MAX_HEIGHT entries (4096 by default), before s_tready rises.
// The result is held in an output register; a stalled receiver only holds
// the next result back, the following request may already be accepted.
`default_nettype none

module raster_line_and_flood_fill
  import rlff_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // x0, y0, x1, y1, red_in, green_in, blue_in, wrap_u, wrap_v, zero pad
  input  wire logic [55:0]      s_tdata,
  // req_type
  input  wire logic [1:0]       s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // red_out, green_out, blue_out, status, zero pad
  output logic [31:0]           m_tdata,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cmd_t             cmd;
  stat_t            stat;
  logic [PIX_W-1:0] rd_out;
  logic             status_out;

  rlff_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .req(req_t'(s_tuser)),
    .s_tready(s_tready), .stat(stat), .cmd(cmd)
  );

  rlff_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .req(req_t'(s_tuser)),
    .x0_in(s_tdata[5:0]), .y0_in(s_tdata[11:6]),
    .x1_in(s_tdata[17:12]), .y1_in(s_tdata[23:18]),
    .col_in({s_tdata[31:24], s_tdata[39:32], s_tdata[47:40]}),
    .wu_in(s_tdata[48]), .wv_in(s_tdata[49]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .rd_out(rd_out), .status_out(status_out)
  );

  // Pack the result item
  assign m_tdata = {7'b0, status_out, rd_out[7:0], rd_out[15:8], rd_out[23:16]};

endmodule

`default_nettype wire

### design/rlff_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rlff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/rlff_ctrl.sv
// Controller state machine of the raster line and flood fill engine.
`default_nettype none

module rlff_ctrl
  import rlff_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  input  wire req_t  req,
  output logic       s_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (stat.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (s_tvalid) begin
          case (req)
            REQ_LINE: state_next = ST_LN_PREP;
            REQ_FILL: state_next = ST_FL_ADDR;
            default:  state_next = ST_PIX_ADDR;
          endcase
        end
      end
      ST_PIX_ADDR: state_next = ST_PIX_ACC;
      ST_PIX_ACC:  state_next = ST_PIX_CAP;
      ST_PIX_CAP:  state_next = ST_DONE;
      ST_LN_PREP:  state_next = ST_LN_INIT;
      ST_LN_INIT:  state_next = ST_LN_MOD;
      ST_LN_MOD:   if (stat.mod_last) state_next = ST_LN_ADDR;
      ST_LN_ADDR:  state_next = ST_LN_WR;
      ST_LN_WR:    state_next = stat.ln_end ? ST_DONE : ST_LN_ADDR;
      ST_FL_ADDR:  state_next = ST_FL_RD;
      ST_FL_RD:    state_next = ST_FL_CHK;
      ST_FL_CHK:   state_next = stat.fl_reject ? ST_DONE : ST_FL_CLRV;
      ST_FL_CLRV:  if (stat.clr_last) state_next = ST_FL_SEED;
      ST_FL_SEED:  state_next = ST_FL_POP;
      ST_FL_POP:   state_next = stat.cnt_zero ? ST_DONE : ST_FL_PXY;
      ST_FL_PXY:   state_next = ST_FL_PADDR;
      ST_FL_PADDR: state_next = ST_FL_PRD;
      ST_FL_PRD:   state_next = ST_FL_PCHK;
      ST_FL_PCHK:  state_next = stat.pix_match ? ST_FL_NB : ST_FL_POP;
      ST_FL_NB:    state_next = ST_FL_NRD;
      ST_FL_NRD: begin
        if (stat.nvalid) state_next = ST_FL_NCHK;
        else state_next = stat.dir_last ? ST_FL_POP : ST_FL_NB;
      end
      ST_FL_NCHK:  state_next = stat.dir_last ? ST_FL_POP : ST_FL_NB;
      ST_DONE:     if (stat.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr_fb = 1'b1;
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.cap_in = s_tvalid;
      end
      ST_PIX_ADDR: cmd.pix_addr = 1'b1;
      ST_PIX_ACC:  cmd.pix_wr   = 1'b1;
      ST_PIX_CAP:  cmd.pix_cap  = 1'b1;
      ST_LN_PREP:  cmd.ln_prep  = 1'b1;
      ST_LN_INIT:  cmd.ln_init  = 1'b1;
      ST_LN_MOD:   cmd.mod_step = 1'b1;
      ST_LN_ADDR:  cmd.ln_addr  = 1'b1;
      ST_LN_WR:    cmd.ln_wr    = 1'b1;
      ST_FL_ADDR:  cmd.pix_addr = 1'b1;
      ST_FL_RD:    cmd          = '0;
      ST_FL_CHK:   cmd.fl_chk   = 1'b1;
      ST_FL_CLRV:  cmd.clr_vis  = 1'b1;
      ST_FL_SEED:  cmd.seed     = 1'b1;
      ST_FL_POP:   cmd.pop      = !stat.cnt_zero;
      ST_FL_PXY:   cmd.pxy      = 1'b1;
      ST_FL_PADDR: cmd.paddr    = 1'b1;
      ST_FL_PRD:   cmd          = '0;
      ST_FL_PCHK:  cmd.pwr      = stat.pix_match;
      ST_FL_NB:    cmd.nb       = 1'b1;
      ST_FL_NRD:   cmd.dir_inc  = !stat.nvalid && !stat.dir_last;
      ST_FL_NCHK: begin
        cmd.nchk    = 1'b1;
        cmd.dir_inc = !stat.dir_last;
      end
      ST_DONE:     cmd.res_load = stat.out_free;
      default:     cmd          = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/rlff_dp.sv
// Datapath: surface registers, framebuffer, visited map, fill stack and line walker.
`default_nettype none

module rlff_dp
  import rlff_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  output stat_t                 stat,
  input  wire req_t             req,
  input  wire logic [CRD_W-1:0] x0_in,
  input  wire logic [CRD_W-1:0] y0_in,
  input  wire logic [CRD_W-1:0] x1_in,
  input  wire logic [CRD_W-1:0] y1_in,
  input  wire logic [PIX_W-1:0] col_in,
  input  wire logic             wu_in,
  input  wire logic             wv_in,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [PIX_W-1:0]      rd_out,
  output logic                  status_out
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = XW + YW;
  localparam int CNW   = $clog2(DEPTH + 1);
  localparam int PW    = AW + 7;
  localparam int LW    = $clog2(64 + MAX_WIDTH + MAX_HEIGHT) + 1;
  localparam int UW    = LW - 1;
  localparam int KW    = $clog2(UW);
  localparam int DW    = UW + WW + HW;
  localparam int EW    = LW + 1;

  typedef enum logic [1:0] {DIR_XP, DIR_XM, DIR_YP, DIR_YM} dir_t;

  function automatic logic signed [LW-1:0] iabs(input logic signed [LW-1:0] v);
    iabs = v < 0 ? -v : v;
  endfunction

  // Configuration and effective surface size
  logic [CFG_W-1:0] cfg_w, cfg_h;
  logic [WW-1:0]    w;
  logic [HW-1:0]    h;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= CFG_W'(64);
      cfg_h <= CFG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH_IDX:  cfg_w <= cfg_data;
        CFG_HEIGHT_IDX: cfg_h <= cfg_data;
        default:        cfg_w <= cfg_w;
      endcase
    end
  end

  always_comb begin
    if (cfg_w == '0) w = WW'(1);
    else if (int'(cfg_w) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(cfg_w);
    if (cfg_h == '0) h = HW'(1);
    else if (int'(cfg_h) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
    else h = HW'(cfg_h);
  end

  // Latched item
  req_t             req_q;
  logic [CRD_W-1:0] x0q, y0q, x1q, y1q;
  logic [PIX_W-1:0] col;
  logic             wu, wv;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      req_q <= req;
      x0q   <= x0_in;
      y0q   <= y0_in;
      x1q   <= x1_in;
      y1q   <= y1_in;
      col   <= col_in;
      wu    <= wu_in;
      wv    <= wv_in;
    end
  end

  // Memories
  logic             fb_we, vis_we, vis_wdata, st_we, vis_rdata;
  logic [AW-1:0]    fb_waddr, vis_waddr, st_waddr, st_raddr, addr, clr_addr;
  logic [PIX_W-1:0] fb_wdata, fb_rdata, orig, rd;
  logic [SW-1:0]    st_wdata, st_rdata;
  logic [CNW-1:0]   cnt;
  logic             inr, stat_bit, push;
  logic [XW-1:0]    px, nx, nx_c;
  logic [YW-1:0]    py, ny, ny_c;
  logic             nv, nv_c;
  dir_t             dir;

  rlff_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_fb (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(addr), .rdata(fb_rdata)
  );

  rlff_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(addr), .rdata(vis_rdata)
  );

  rlff_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  assign push = cmd.nchk && nv && !vis_rdata && (fb_rdata == orig) && (cnt < CNW'(DEPTH));

  assign fb_we    = cmd.clr_fb || cmd.ln_wr || cmd.pwr ||
                    (cmd.pix_wr && inr && (req_q == REQ_SET));
  assign fb_waddr = cmd.clr_fb ? clr_addr : addr;
  assign fb_wdata = cmd.clr_fb ? WHITE : col;

  assign vis_we    = cmd.clr_vis || cmd.seed || push;
  assign vis_waddr = cmd.clr_vis ? clr_addr : addr;
  assign vis_wdata = !cmd.clr_vis;

  assign st_we    = cmd.seed || push;
  assign st_waddr = cmd.seed ? '0 : cnt[AW-1:0];
  assign st_wdata = cmd.seed ? {YW'(y0q), XW'(x0q)} : {ny, nx};
  assign st_raddr = AW'(cnt - CNW'(1));

  // Clearing sweep over the whole store
  assign stat.clr_last = clr_addr == AW'(DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_fb || cmd.clr_vis) begin
      clr_addr <= stat.clr_last ? '0 : clr_addr + AW'(1);
    end
  end

  // Line walker
  logic signed [LW-1:0] xa, ya, xb, yb, xa_c, ya_c, xb_c, yb_c, wl, hl;
  logic signed [LW-1:0] x, y, dx, dy;
  logic signed [EW-1:0] err, err_n;
  logic signed [EW:0]   e2;
  logic                 sxp, syp, step_x, step_y;
  logic [UW-1:0]        rx, ry, rx_n, ry_n;
  logic [KW-1:0]        k;
  logic [DW-1:0]        shw, shh;

  assign wl = LW'(w);
  assign hl = LW'(h);

  // Take the shorter toroidal path when wrapping is allowed
  always_comb begin
    xa_c = LW'(x0q);
    xb_c = LW'(x1q);
    ya_c = LW'(y0q);
    yb_c = LW'(y1q);
    if (wu && iabs(xb_c - xa_c) > (wl >>> 1)) begin
      if (xb_c > xa_c) xa_c = xa_c + wl;
      else xb_c = xb_c + wl;
    end
    if (wv && iabs(yb_c - ya_c) > (hl >>> 1)) begin
      if (yb_c > ya_c) ya_c = ya_c + hl;
      else yb_c = yb_c + hl;
    end
  end

  assign shw = DW'(w) << k;
  assign shh = DW'(h) << k;
  assign stat.mod_last = k == '0;
  assign stat.ln_end   = (x == xb) && (y == yb);

  // Bresenham step with the wrapped position tracked alongside
  always_comb begin
    e2     = EW'(err) <<< 1;
    step_x = e2 > -(EW + 1)'(dy);
    step_y = e2 < (EW + 1)'(dx);
    err_n  = err;
    rx_n   = rx;
    ry_n   = ry;
    if (step_x) begin
      err_n = err_n - EW'(dy);
      if (sxp) rx_n = (rx == UW'(w) - UW'(1)) ? '0 : rx + UW'(1);
      else rx_n = (rx == '0) ? UW'(w) - UW'(1) : rx - UW'(1);
    end
    if (step_y) begin
      err_n = err_n + EW'(dx);
      if (syp) ry_n = (ry == UW'(h) - UW'(1)) ? '0 : ry + UW'(1);
      else ry_n = (ry == '0) ? UW'(h) - UW'(1) : ry - UW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ln_prep) begin
      xa <= xa_c;
      ya <= ya_c;
      xb <= xb_c;
      yb <= yb_c;
    end
    if (cmd.ln_init) begin
      dx  <= iabs(xb - xa);
      dy  <= iabs(yb - ya);
      err <= EW'(iabs(xb - xa)) - EW'(iabs(yb - ya));
      sxp <= xa < xb;
      syp <= ya < yb;
      x   <= xa;
      y   <= ya;
      rx  <= UW'(xa);
      ry  <= UW'(ya);
      k   <= KW'(UW - 1);
    end
    // One restoring remainder bit per cycle for both axes
    if (cmd.mod_step) begin
      if (DW'(rx) >= shw) rx <= UW'(DW'(rx) - shw);
      if (DW'(ry) >= shh) ry <= UW'(DW'(ry) - shh);
      k <= k - KW'(1);
    end
    if (cmd.ln_wr && !stat.ln_end) begin
      err <= err_n;
      rx  <= rx_n;
      ry  <= ry_n;
      if (step_x) x <= sxp ? x + LW'(1) : x - LW'(1);
      if (step_y) y <= syp ? y + LW'(1) : y - LW'(1);
    end
  end

  // Neighbor of the current fill pixel
  always_comb begin
    nx_c = px;
    ny_c = py;
    nv_c = 1'b1;
    case (dir)
      DIR_XP: begin
        if (WW'(px) + WW'(1) == w) begin
          if (wu) nx_c = '0;
          else nv_c = 1'b0;
        end else nx_c = px + XW'(1);
      end
      DIR_XM: begin
        if (px == '0) begin
          if (wu) nx_c = XW'(w - WW'(1));
          else nv_c = 1'b0;
        end else nx_c = px - XW'(1);
      end
      DIR_YP: begin
        if (HW'(py) + HW'(1) == h) begin
          if (wv) ny_c = '0;
          else nv_c = 1'b0;
        end else ny_c = py + YW'(1);
      end
      DIR_YM: begin
        if (py == '0) begin
          if (wv) ny_c = YW'(h - HW'(1));
          else nv_c = 1'b0;
        end else ny_c = py - YW'(1);
      end
      default: nv_c = 1'b0;
    endcase
  end

  assign stat.fl_reject = !inr || (fb_rdata == col);
  assign stat.cnt_zero  = cnt == '0;
  assign stat.pix_match = fb_rdata == orig;
  assign stat.nvalid    = nv;
  assign stat.dir_last  = dir == DIR_YM;
  assign stat.out_free  = !m_tvalid || m_tready;

  // Addresses, fill state and result
  always_ff @(posedge clk) begin
    if (cmd.pix_addr) begin
      inr      <= (PW'(x0q) < PW'(w)) && (PW'(y0q) < PW'(h));
      stat_bit <= !((PW'(x0q) < PW'(w)) && (PW'(y0q) < PW'(h)));
      addr     <= AW'(PW'(y0q) * PW'(w) + PW'(x0q));
    end
    if (cmd.ln_addr) addr <= AW'(PW'(ry) * PW'(w) + PW'(rx));
    if (cmd.paddr) addr <= AW'(PW'(py) * PW'(w) + PW'(px));
    if (cmd.nb) begin
      nx   <= nx_c;
      ny   <= ny_c;
      nv   <= nv_c;
      addr <= AW'(PW'(ny_c) * PW'(w) + PW'(nx_c));
    end
    if (cmd.pix_cap) rd <= (inr && req_q == REQ_READ) ? fb_rdata : '0;
    if (cmd.fl_chk) begin
      stat_bit <= stat.fl_reject;
      orig     <= fb_rdata;
    end
    if (cmd.pxy) begin
      px <= st_rdata[XW-1:0];
      py <= st_rdata[SW-1:XW];
    end
    if (cmd.cap_in) begin
      rd       <= '0;
      stat_bit <= 1'b0;
    end
    if (cmd.res_load) begin
      rd_out     <= rd;
      status_out <= stat_bit;
    end
  end

  // Control registers: stack count, direction and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      dir      <= DIR_XP;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.seed) cnt <= CNW'(1);
      else if (cmd.pop) cnt <= cnt - CNW'(1);
      else if (push) cnt <= cnt + CNW'(1);
      if (cmd.pwr) dir <= DIR_XP;
      else if (cmd.dir_inc) dir <= dir_t'(dir + 2'd1);
      if (cmd.res_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CNW'(DEPTH))
    else $error("fill stack count beyond depth");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a waiting item");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst) cmd.cap_in |-> cnt == '0)
    else $error("fill stack not empty at new item");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) cmd.pop |-> cnt != '0)
    else $error("pop of empty fill stack");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the raster line and flood fill engine.
`default_nettype none

module tb;
  import rlff_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = 64;
  localparam int MAXH = 64;
  localparam int CELLS = MAXW * MAXH;

  typedef struct packed {
    logic       wrap_v;
    logic       wrap_u;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [5:0] y1;
    logic [5:0] x1;
    logic [5:0] y0;
    logic [5:0] x0;
  } draw_fields_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        status;
  } pix_result_t;

  // One row of the directed table; chk set means the result is typed in
  typedef struct {
    req_t         req;
    draw_fields_t f;
    logic         chk;
    pix_result_t  res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  raster_line_and_flood_fill u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow surface state
  logic [23:0] shadow_fb [CELLS];
  bit          fill_seen [CELLS];
  int          fill_todo [$];
  logic [6:0]  width_reg = 7'd64;
  logic [6:0]  height_reg = 7'd64;

  pix_result_t pending_px [$];
  int  errors = 0;
  bit  quiet_tail = 0;

  function automatic int surf_w();
    if (width_reg < 1) return 1;
    if (width_reg > MAXW) return MAXW;
    return width_reg;
  endfunction

  function automatic int surf_h();
    if (height_reg < 1) return 1;
    if (height_reg > MAXH) return MAXH;
    return height_reg;
  endfunction

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void plot_line(draw_fields_t f);
    int w, h, xa, ya, xb, yb, dx, dy, sx, sy, err, e2, x, y;
    logic [23:0] c;
    w = surf_w(); h = surf_h();
    xa = f.x0; ya = f.y0; xb = f.x1; yb = f.y1;
    c = {f.red, f.green, f.blue};
    if (f.wrap_u && iabs(xb - xa) > w / 2) begin
      if (xb > xa) xa += w; else xb += w;
    end
    if (f.wrap_v && iabs(yb - ya) > h / 2) begin
      if (yb > ya) ya += h; else yb += h;
    end
    dx = iabs(xb - xa); dy = iabs(yb - ya);
    sx = xa < xb ? 1 : -1; sy = ya < yb ? 1 : -1;
    err = dx - dy; x = xa; y = ya;
    forever begin
      shadow_fb[(y % h) * w + (x % w)] = c;
      if (x == xb && y == yb) break;
      e2 = 2 * err;
      if (e2 > -dy) begin err -= dy; x += sx; end
      if (e2 < dx) begin err += dx; y += sy; end
    end
  endfunction

  function automatic bit fill_area(draw_fields_t f);
    int w, h, idx, px, py, nx, ny, n;
    logic [23:0] c, orig;
    w = surf_w(); h = surf_h();
    c = {f.red, f.green, f.blue};
    if (f.x0 >= w || f.y0 >= h) return 0;
    orig = shadow_fb[f.y0 * w + f.x0];
    if (orig == c) return 0;
    foreach (fill_seen[i]) fill_seen[i] = 0;
    fill_todo.delete();
    fill_todo.push_back(f.y0 * w + f.x0);
    fill_seen[f.y0 * w + f.x0] = 1;
    while (fill_todo.size() > 0) begin
      idx = fill_todo.pop_back();
      px = idx % w; py = idx / w;
      if (shadow_fb[idx] != orig) continue;
      shadow_fb[idx] = c;
      for (int i = 0; i < 4; i++) begin
        nx = px + (i == 0 ? 1 : i == 1 ? -1 : 0);
        ny = py + (i == 2 ? 1 : i == 3 ? -1 : 0);
        if (f.wrap_u && (nx < 0 || nx >= w)) nx = (nx + w) % w;
        if (f.wrap_v && (ny < 0 || ny >= h)) ny = (ny + h) % h;
        if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
        n = ny * w + nx;
        if (!fill_seen[n] && shadow_fb[n] == orig && fill_todo.size() < CELLS) begin
          fill_seen[n] = 1;
          fill_todo.push_back(n);
        end
      end
    end
    return 1;
  endfunction

  // Advance the shadow surface by one request and return its result
  function automatic pix_result_t apply_request(req_t rq, draw_fields_t f);
    pix_result_t r;
    int w, h;
    w = surf_w(); h = surf_h();
    r = '0;
    case (rq)
      REQ_SET: begin
        if (f.x0 < w && f.y0 < h) shadow_fb[f.y0 * w + f.x0] = {f.red, f.green, f.blue};
        else r.status = 1'b1;
      end
      REQ_LINE: plot_line(f);
      REQ_FILL: r.status = !fill_area(f);
      default: begin
        if (f.x0 < w && f.y0 < h) r.rgb = shadow_fb[f.y0 * w + f.x0];
        else r.status = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Send one request, queue its expected result
  task automatic send_request(req_t rq, draw_fields_t f, bit typed, pix_result_t typed_res);
    pix_result_t r;
    while (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    r = apply_request(rq, f);
    if (typed && r != typed_res) begin
      $display("%0t: table row disagrees: expected %h predicted %h", $time, typed_res, r);
      errors++;
    end
    pending_px.push_back(typed ? typed_res : r);
    s_tvalid <= 1'b1;
    s_tuser <= rq;
    s_tdata <= {6'd0, f.wrap_v, f.wrap_u, f.blue, f.green, f.red, f.y1, f.x1, f.y0, f.x0};
    do @(posedge clk); while (!s_tready);
  endtask

  // Receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_px.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          errors++;
        end else begin
          pix_result_t e;
          e = pending_px.pop_front();
          if (m_tdata[23:0] != {e.rgb[7:0], e.rgb[15:8], e.rgb[23:16]} ||
              m_tdata[24] != e.status || m_tdata[31:25] != '0) begin
            $display("%0t: mismatch expected rgb %h status %b, actual rgb %h%h%h status %b",
                     $time, e.rgb, e.status, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                     m_tdata[24]);
            errors++;
          end
        end
      end
      m_tready <= quiet_tail ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WIDTH_IDX) width_reg = v; else height_reg = v;
    @(posedge clk);
  endtask

  function automatic draw_fields_t rand_fields(int w, int h);
    draw_fields_t f;
    f = draw_fields_t'({$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) begin
      f.x0 = $urandom_range(0, w - 1); f.y0 = $urandom_range(0, h - 1);
      f.x1 = $urandom_range(0, w - 1); f.y1 = $urandom_range(0, h - 1);
    end
    // A few palettes so fills meet regions of equal color
    if ($urandom_range(0, 2) != 0) {f.red, f.green, f.blue} = $urandom_range(0, 3) * 24'h404040;
    return f;
  endfunction

  dir_row_t dir_rows [$];

  function automatic dir_row_t mk(req_t rq, int x0, int y0, int x1, int y1, logic [23:0] c,
                                  bit wu, bit wv, bit chk, logic [23:0] rgb, bit st);
    dir_row_t d;
    d.req = rq;
    d.f = {wv, wu, c[7:0], c[15:8], c[23:16], 6'(y1), 6'(x1), 6'(y0), 6'(x0)};
    d.chk = chk;
    d.res = {rgb, st};
    return d;
  endfunction

  initial begin
    req_t rq;
    int sizes [8] = '{64, 1, 2, 3, 7, 16, 33, 64};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (shadow_fb[i]) shadow_fb[i] = WHITE;

    // Directed table
    dir_rows.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1, WHITE, 0));
    dir_rows.push_back(mk(REQ_READ, 63, 63, 0, 0, 0, 0, 0, 1, WHITE, 0));
    dir_rows.push_back(mk(REQ_FILL, 5, 5, 0, 0, WHITE, 0, 0, 1, 0, 1));
    dir_rows.push_back(mk(REQ_SET, 63, 0, 0, 0, 24'h123456, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk(REQ_READ, 63, 0, 0, 0, 0, 0, 0, 1, 24'h123456, 0));
    dir_rows.push_back(mk(REQ_SET, 0, 63, 0, 0, 24'h000000, 1, 1, 1, 0, 0));
    dir_rows.push_back(mk(REQ_LINE, 0, 0, 63, 63, 24'hFF0000, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk(REQ_LINE, 2, 10, 60, 10, 24'h00FF00, 1, 0, 1, 0, 0));
    dir_rows.push_back(mk(REQ_LINE, 10, 61, 12, 1, 24'h0000FF, 0, 1, 1, 0, 0));
    dir_rows.push_back(mk(REQ_LINE, 30, 30, 30, 30, 24'hAAAAAA, 1, 1, 1, 0, 0));
    dir_rows.push_back(mk(REQ_LINE, 63, 5, 0, 40, 24'h555555, 1, 1, 1, 0, 0));
    dir_rows.push_back(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(REQ_READ, 62, 10, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(REQ_FILL, 40, 3, 0, 0, 24'h000000, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk(REQ_FILL, 40, 3, 0, 0, 24'h000000, 0, 0, 1, 0, 1));
    dir_rows.push_back(mk(REQ_FILL, 1, 50, 0, 0, 24'hFFFFFF, 1, 1, 1, 0, 1));
    dir_rows.push_back(mk(REQ_READ, 40, 3, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(REQ_READ, 20, 50, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].f, dir_rows[i].chk,
                                       dir_rows[i].res);
    drain();

    // Out-of-range register values saturate
    write_cfg(CFG_WIDTH_IDX, 7'd0);
    write_cfg(CFG_HEIGHT_IDX, 7'd127);
    send_request(REQ_SET, draw_fields_t'({6'd0, 6'd0, 6'd0, 6'd1} | 48'h0), 1, '{0, 1});
    send_request(REQ_READ, draw_fields_t'(0), 0, '0);
    send_request(REQ_LINE, draw_fields_t'({2'b11, 24'h00FF00, 6'd9, 6'd50, 6'd0, 6'd63}), 0, '0);
    send_request(REQ_FILL, draw_fields_t'({2'b11, 24'h808080, 6'd0, 6'd0, 6'd20, 6'd0}), 0, '0);
    drain();

    // Random phases over several surface sizes
    for (int ph = 0; ph < 8; ph++) begin
      int w, h;
      write_cfg(CFG_WIDTH_IDX, (ph == 7) ? 7'd64 : 7'(sizes[$urandom_range(0, 7)]));
      write_cfg(CFG_HEIGHT_IDX, (ph == 0) ? 7'd1 : 7'(sizes[$urandom_range(0, 7)]));
      w = surf_w(); h = surf_h();
      if (ph == 7) quiet_tail = 1;
      for (int k = 0; k < 210; k++) begin
        rq = req_t'($urandom_range(0, 9) < 3 ? REQ_READ : $urandom_range(0, 3));
        send_request(rq, rand_fields(w, h), 0, '0);
      end
      drain();
    end

    if (errors == 0) $display("raster_line_and_flood_fill test passed");
    else $display("raster_line_and_flood_fill test failed");
    $finish;
  end

  initial begin
    #2s;
    $display("raster_line_and_flood_fill test failed");
    $finish;
  end
endmodule

`default_nettype wire
